/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/mmt_pkg.sv */
// ----------------------------------------------------------------------------
// Multicast member table package
// Transaction types, protocol constants and action codes.
// ----------------------------------------------------------------------------
package mmt_pkg;

    localparam int          MAX_MEMBERS_DEF = 256;
    localparam logic [7:0]  PROTO_IGMP      = 8'd2;
    localparam logic [7:0]  REC_JOIN        = 8'd4;
    localparam logic [7:0]  REC_LEAVE       = 8'd3;
    localparam logic [31:0] GROUP_RESET     = 32'hE000_4343;

    localparam logic [2:0] ACT_IGNORED = 3'd0;
    localparam logic [2:0] ACT_ADDED   = 3'd1;
    localparam logic [2:0] ACT_PRESENT = 3'd2;
    localparam logic [2:0] ACT_REMOVED = 3'd3;
    localparam logic [2:0] ACT_ABSENT  = 3'd4;
    localparam logic [2:0] ACT_FULL    = 3'd5;

    typedef struct packed {
        logic [7:0]  ip_protocol;
        logic [7:0]  record_type;
        logic [31:0] record_group;
        logic [31:0] sender_address;
    } t_mmt_in;

    typedef struct packed {
        logic [2:0] action;
        logic [8:0] member_count;
    } t_mmt_out;

endpackage

/* rtl/mmt_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/multicast_member_table.sv */
// ----------------------------------------------------------------------------
// Multicast member table
// Tracks the senders that joined one watched multicast group from IGMPv3
// report summaries, with a sequential search through a member RAM.
// ----------------------------------------------------------------------------
//  channel   direction  payload     handshake
//  in        input      t_mmt_in    i_in_valid  / o_in_stall
//  out       output     t_mmt_out   o_out_valid / i_out_stall
//  cfg       input      32b group   i_cfg_wr_en / i_cfg_wr_data
//
//  An ignored report goes straight to the result state; a join or leave
//  searches the member RAM, reading one RAM entry per cycle, and a leave
//  that finds the sender then moves the last entry into its slot.
//  Reset clears the member count and loads the watched group 224.0.67.67.
//  The output register frees the input side while a result is stalled.
// ----------------------------------------------------------------------------
module multicast_member_table #(
    parameter int MAX_MEMBERS = mmt_pkg::MAX_MEMBERS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [31:0]      i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  mmt_pkg::t_mmt_in i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output mmt_pkg::t_mmt_out o_out_data
);

    import mmt_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_MEMBERS);
    localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MEMBERS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_RD_LAST,
        S_MOVE,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [31:0]      r_watched;
    logic [31:0]      r_sender, n_sender;
    logic             r_is_join, n_is_join;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_cmp_valid, n_cmp_valid;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic [2:0]       r_act, n_act;
    logic             r_out_valid, n_out_valid;
    t_mmt_out         r_out_data, n_out_data;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [31:0]      ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [31:0]      ram_rdata;
    logic             in_acc;
    logic             relevant;
    logic             hit;
    logic             search_end;

    mmt_ram #(
        .WIDTH(32),
        .DEPTH(MAX_MEMBERS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign relevant    = (i_in_data.ip_protocol == PROTO_IGMP)
                      && (i_in_data.record_group == r_watched)
                      && ((i_in_data.record_type == REC_JOIN)
                       || (i_in_data.record_type == REC_LEAVE));
    assign hit         = r_cmp_valid && (ram_rdata == r_sender);
    assign search_end  = !hit && (r_idx == r_count);

    always_comb begin
        ram_raddr = (r_state == S_SEARCH) ? r_idx[IDX_W-1:0]
                                          : IDX_W'(r_count - 1'b1);
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = ram_rdata;
        if (r_state == S_MOVE) begin
            ram_we = 1'b1;
        end else if (r_state == S_SEARCH && search_end && r_is_join
                     && (r_count < CNT_MAX)) begin
            ram_we    = 1'b1;
            ram_waddr = r_count[IDX_W-1:0];
            ram_wdata = r_sender;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sender    = r_sender;
        n_is_join   = r_is_join;
        n_count     = r_count;
        n_idx       = r_idx;
        n_cmp_valid = r_cmp_valid;
        n_cmp_idx   = r_cmp_idx;
        n_slot      = r_slot;
        n_act       = r_act;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_sender    = i_in_data.sender_address;
                    n_is_join   = (i_in_data.record_type == REC_JOIN);
                    n_idx       = '0;
                    n_cmp_valid = 1'b0;
                    if (relevant) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_act   = ACT_IGNORED;
                        n_state = S_DONE;
                    end
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    if (r_is_join) begin
                        n_act   = ACT_PRESENT;
                        n_state = S_DONE;
                    end else begin
                        n_slot  = r_cmp_idx;
                        n_state = S_RD_LAST;
                    end
                end else if (search_end) begin
                    n_state = S_DONE;
                    if (!r_is_join) begin
                        n_act = ACT_ABSENT;
                    end else if (r_count >= CNT_MAX) begin
                        n_act = ACT_FULL;
                    end else begin
                        n_act   = ACT_ADDED;
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_idx[IDX_W-1:0];
                    n_idx       = r_idx + 1'b1;
                end
            end
            S_RD_LAST: begin
                n_state = S_MOVE;
            end
            S_MOVE: begin
                n_count = r_count - 1'b1;
                n_act   = ACT_REMOVED;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid             = 1'b1;
                    n_out_data.action       = r_act;
                    n_out_data.member_count = 9'(r_count);
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_watched   <= GROUP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_cmp_valid <= n_cmp_valid;
            if (i_cfg_wr_en) begin
                r_watched <= i_cfg_wr_data;
            end
        end
        r_sender   <= n_sender;
        r_is_join  <= n_is_join;
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_slot     <= n_slot;
        r_act      <= n_act;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_MAX, "member count over limit")
    `ASSERT_IMPLY(a_count_step, i_clk, i_rst_n, $past(i_rst_n) && (r_count != $past(r_count)), (r_count == $past(r_count) + 1'b1) || (r_count == $past(r_count) - 1'b1), "member count jumped")
    `ASSERT_IMPLY(a_search_idx, i_clk, i_rst_n, r_state == S_SEARCH, r_idx <= r_count, "search index past count")
    `ASSERT_IMPLY(a_out_hold, i_clk, i_rst_n, $past(i_rst_n) && $past(r_out_valid) && $past(i_out_stall), r_out_valid && $stable(r_out_data), "stalled result changed")

endmodule
